### rtl/core/mbrtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;

  localparam int unsigned TableLenDef = 128;
  localparam int unsigned FrameMaxDef = 64;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned TxMax       = 64;
  localparam int unsigned RegBase     = 16;
  localparam int unsigned WrMinAddr   = 8;
  localparam int unsigned ExcReg      = 1;
  localparam int unsigned MultiHdr    = 9;
  localparam int unsigned MultiMinLen = 11;
  localparam int unsigned SingleLen   = 8;
  localparam int unsigned ExcLen      = 4;
  localparam int unsigned HdrBytes    = 7;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FnReadHold   = 8'h03;
  localparam logic [7:0] FnReadInput  = 8'h04;
  localparam logic [7:0] FnWriteOne   = 8'h06;
  localparam logic [7:0] FnExcStatus  = 8'h07;
  localparam logic [7:0] FnEcho       = 8'h08;
  localparam logic [7:0] FnWriteMulti = 8'd16;

  localparam logic CfgDeviceId   = 1'b0;
  localparam logic CfgManualMode = 1'b1;

  typedef enum logic [2:0] {
    ST_OK,
    ST_LENGTH,
    ST_ADDRESS,
    ST_COUNT,
    ST_LOCK,
    ST_FUNC,
    ST_OVERFLOW
  } status_e;

  typedef enum logic {
    CMD_BYTE,
    CMD_LOCAL
  } cmd_kind_e;

  typedef enum logic [2:0] {
    PLAN_READ,
    PLAN_EXC,
    PLAN_W6,
    PLAN_ECHO,
    PLAN_W16
  } plan_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ERR,
    S_HDR,
    S_RFRD,
    S_RFHI,
    S_RFLO,
    S_CRC_LO,
    S_CRC_HI,
    S_W6,
    S_ECHO_RD,
    S_ECHO_TX,
    S_W16_RDH,
    S_W16_RDL,
    S_W16_WR
  } back_state_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic [7:0]  local_addr;
    logic [15:0] local_value;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    status_e     status;
    logic        crc_ok;
    logic        params_written;
  } out_word_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  data;
    logic        last;
    logic [7:0]  addr;
    logic [15:0] value;
  } cmd_t;

  function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/mbrtu_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_front import mbrtu_pkg::*; #(
  parameter int unsigned NRegs = RegBase + TableLenDef
) (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  logic is_local;
  logic in_range;

  assign is_local   = in_word_i.kind;
  assign in_range   = {1'b0, in_word_i.local_addr} < 9'(NRegs);
  assign in_stall_o = q_full_i;

  // drop device writes past the register file
  assign q_push_o = in_valid_i && !q_full_i && (!is_local || in_range);

  always_comb begin
    q_cmd_o.kind  = is_local ? CMD_LOCAL : CMD_BYTE;
    q_cmd_o.data  = in_word_i.rx_byte;
    q_cmd_o.last  = in_word_i.frame_end;
    q_cmd_o.addr  = in_word_i.local_addr;
    q_cmd_o.value = in_word_i.local_value;
  end

endmodule
`default_nettype wire

### rtl/core/mbrtu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_fifo import mbrtu_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o    = cnt_q == CntW'(Depth);
  assign empty_o   = cnt_q == '0;
  assign pop_cmd_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    end
    if (pop_i) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/mbrtu_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_back import mbrtu_pkg::*; #(
  parameter int unsigned TableLen = TableLenDef,
  parameter int unsigned FrameMax = FrameMaxDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic      q_empty_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned NRegs = RegBase + TableLen;
  localparam int unsigned RfAw  = $clog2(NRegs);
  localparam int unsigned BufAw = $clog2(FrameMax);
  localparam int unsigned CntW  = $clog2(FrameMax + 1);

  back_state_e state_q, state_d;

  logic [7:0]      dev_q, dev_d;
  logic            man_q, man_d;

  logic [CntW-1:0] cnt_q, cnt_d, len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [15:0]     crc0_q, crc0_d, crc1_q, crc1_d, crc2_q, crc2_d;
  logic [7:0]      b0_q, b0_d, b1_q, b1_d;
  logic [7:0]      hdr_q [HdrBytes];
  logic            hdr_we;
  logic [2:0]      hdr_wa;
  logic            crcok_q, crcok_d;
  status_e         status_q, status_d;
  plan_e           plan_q, plan_d;
  logic            pw_q, pw_d;
  logic [7:0]      idx_q, idx_d;
  logic [RfAw-1:0] ra_q, ra_d;
  logic [15:0]     txc_q, txc_d;
  logic [7:0]      hi_q, hi_d;

  logic [7:0]      buf_mem [FrameMax];
  logic [7:0]      buf_rd_q;
  logic            buf_we;
  logic [BufAw-1:0] buf_wa, buf_ra;

  logic [15:0]     rf_mem [NRegs];
  logic [NRegs-1:0] rf_vld_q;
  logic [15:0]     rf_rd_q;
  logic            rf_rv_q;
  logic            rf_we, rf_re;
  logic [RfAw-1:0] rf_wa;
  logic [15:0]     rf_wd, rf_data;

  out_word_t       out_q, out_d;
  logic            out_vld_q, out_vld_d;

  logic            emit, emit_ok, e_valid, e_last;
  logic [7:0]      e_byte;
  status_e         e_status;

  logic [15:0]     f_start, f_num;
  logic [7:0]      f_fn, f_bc;
  logic            stored;
  logic [15:0]     c_sel;
  logic [7:0]      hb;
  logic [7:0]      hcnt;
  logic [9:0]      wr_ptr;

  assign rf_data     = rf_rv_q ? rf_rd_q : 16'h0000;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;
  assign emit_ok     = !out_vld_q || !out_stall_i;

  assign f_fn    = hdr_q[1];
  assign f_start = {hdr_q[2], hdr_q[3]};
  assign f_num   = {hdr_q[4], hdr_q[5]};
  assign f_bc    = hdr_q[6];
  assign stored  = cnt_q < CntW'(FrameMax);
  assign wr_ptr  = 10'd7 + {1'b0, idx_q, 1'b0};

  always_comb begin
    case (plan_q)
      PLAN_READ: hcnt = 8'd3;
      PLAN_EXC:  hcnt = 8'd2;
      default:   hcnt = 8'd6;
    endcase
    case (plan_q)
      PLAN_READ: begin
        case (idx_q)
          8'd0:    hb = dev_q;
          8'd1:    hb = f_fn;
          default: hb = {f_num[6:0], 1'b0};
        endcase
      end
      PLAN_EXC: hb = (idx_q == 8'd0) ? dev_q : f_fn;
      default:  hb = hdr_q[idx_q[2:0]];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    dev_d     = dev_q;
    man_d     = man_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    crc0_d    = crc0_q;
    crc1_d    = crc1_q;
    crc2_d    = crc2_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    hdr_we    = 1'b0;
    hdr_wa    = cnt_q[2:0];
    crcok_d   = crcok_q;
    status_d  = status_q;
    plan_d    = plan_q;
    pw_d      = pw_q;
    idx_d     = idx_q;
    ra_d      = ra_q;
    txc_d     = txc_q;
    hi_d      = hi_q;
    buf_we    = 1'b0;
    buf_wa    = cnt_q[BufAw-1:0];
    buf_ra    = idx_q[BufAw-1:0];
    rf_we     = 1'b0;
    rf_re     = 1'b0;
    rf_wa     = q_cmd_i.addr[RfAw-1:0];
    rf_wd     = q_cmd_i.value;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    e_valid   = 1'b1;
    e_byte    = 8'h00;
    e_last    = 1'b0;
    e_status  = ST_OK;
    c_sel     = stored ? crc1_q : crc2_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == CfgDeviceId) begin
        dev_d = cfg_data_i;
      end else begin
        man_d = cfg_data_i[0];
      end
    end

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.kind == CMD_LOCAL) begin
            rf_we = 1'b1;
          end else begin
            if (stored) begin
              buf_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
              hdr_we = cnt_q < CntW'(HdrBytes);
              crc0_d = crc_byte(crc0_q, q_cmd_i.data);
              crc1_d = crc0_q;
              crc2_d = crc1_q;
              b0_d   = q_cmd_i.data;
              b1_d   = b0_q;
            end else begin
              ovf_d = 1'b1;
            end
            if (q_cmd_i.last) begin
              len_d   = stored ? cnt_q + 1'b1 : cnt_q;
              crcok_d = stored && !ovf_q && (cnt_q >= CntW'(1))
                        && ((stored ? b0_q : b1_q) == c_sel[7:0])
                        && ((stored ? q_cmd_i.data : b0_q) == c_sel[15:8]);
              ovf_d   = ovf_q || !stored;
              cnt_d   = '0;
              crc0_d  = CrcInit;
              crc1_d  = CrcInit;
              crc2_d  = CrcInit;
              state_d = S_DECIDE;
            end
          end
        end
      end

      S_DECIDE: begin
        status_d = ST_OK;
        plan_d   = PLAN_ECHO;
        if (ovf_q) begin
          status_d = ST_OVERFLOW;
        end else if (len_q < CntW'(2)) begin
          status_d = ST_LENGTH;
        end else begin
          case (f_fn)
            FnReadHold, FnReadInput: begin
              plan_d = PLAN_READ;
              if (len_q != CntW'(SingleLen)) status_d = ST_LENGTH;
              else if (f_start >= 16'(NRegs)) status_d = ST_ADDRESS;
              else if (f_num == 16'h0000) status_d = ST_COUNT;
              else if (17'(f_start) + 17'(f_num) > 17'(NRegs)) status_d = ST_ADDRESS;
              else if ((18'd5 + {1'b0, f_num, 1'b0} > 18'(FrameMax))
                       || (18'd5 + {1'b0, f_num, 1'b0} > 18'(TxMax))) begin
                status_d = ST_OVERFLOW;
              end
            end
            FnWriteOne: begin
              plan_d = PLAN_W6;
              if (man_q) status_d = ST_LOCK;
              else if (len_q != CntW'(SingleLen)) status_d = ST_LENGTH;
              else if ((f_start >= 16'(NRegs)) || (f_start < 16'(WrMinAddr))) begin
                status_d = ST_ADDRESS;
              end
            end
            FnExcStatus: begin
              plan_d = PLAN_EXC;
              if (len_q != CntW'(ExcLen)) status_d = ST_LENGTH;
            end
            FnEcho: begin
              plan_d = PLAN_ECHO;
              if (10'(len_q) > 10'(TxMax)) status_d = ST_OVERFLOW;
            end
            FnWriteMulti: begin
              plan_d = PLAN_W16;
              if (man_q) status_d = ST_LOCK;
              else if (len_q < CntW'(MultiMinLen)) status_d = ST_LENGTH;
              else if (10'(len_q) != 10'(f_bc) + 10'(MultiHdr)) status_d = ST_LENGTH;
              else if ((f_start >= 16'(NRegs)) || (f_start < 16'(WrMinAddr))) begin
                status_d = ST_ADDRESS;
              end
              else if (f_num == 16'h0000) status_d = ST_COUNT;
              else if (17'(f_start) + 17'(f_num) > 17'(NRegs)) status_d = ST_ADDRESS;
              else if ({f_num, 1'b0} > 17'(f_bc)) status_d = ST_OVERFLOW;
            end
            default: status_d = ST_FUNC;
          endcase
        end
        idx_d   = '0;
        txc_d   = CrcInit;
        ra_d    = f_start[RfAw-1:0];
        pw_d    = (plan_d == PLAN_W6) || (plan_d == PLAN_W16);
        ovf_d   = 1'b0;
        if (status_d != ST_OK) begin
          state_d = S_ERR;
        end else begin
          case (plan_d)
            PLAN_READ, PLAN_EXC: state_d = S_HDR;
            PLAN_W6:             state_d = S_W6;
            PLAN_W16:            state_d = S_W16_RDH;
            default:             state_d = S_ECHO_RD;
          endcase
        end
      end

      S_ERR: begin
        emit     = 1'b1;
        e_valid  = 1'b0;
        e_last   = 1'b1;
        e_status = status_q;
        if (emit_ok) state_d = S_IDLE;
      end

      S_HDR: begin
        emit   = 1'b1;
        e_byte = hb;
        if (emit_ok) begin
          txc_d = crc_byte(txc_q, hb);
          idx_d = idx_q + 1'b1;
          if (idx_q == hcnt - 1'b1) begin
            idx_d = '0;
            case (plan_q)
              PLAN_READ: begin
                ra_d    = f_start[RfAw-1:0];
                state_d = S_RFRD;
              end
              PLAN_EXC: begin
                ra_d    = RfAw'(ExcReg);
                state_d = S_RFRD;
              end
              default: state_d = S_CRC_LO;
            endcase
          end
        end
      end

      S_RFRD: begin
        rf_re   = 1'b1;
        state_d = (plan_q == PLAN_EXC) ? S_RFLO : S_RFHI;
      end

      S_RFHI: begin
        emit   = 1'b1;
        e_byte = rf_data[15:8];
        if (emit_ok) begin
          txc_d   = crc_byte(txc_q, rf_data[15:8]);
          state_d = S_RFLO;
        end
      end

      S_RFLO: begin
        emit   = 1'b1;
        e_byte = rf_data[7:0];
        if (emit_ok) begin
          txc_d = crc_byte(txc_q, rf_data[7:0]);
          idx_d = idx_q + 1'b1;
          ra_d  = ra_q + 1'b1;
          if ((plan_q == PLAN_EXC) || (16'(idx_q) + 16'd1 == f_num)) begin
            state_d = S_CRC_LO;
          end else begin
            state_d = S_RFRD;
          end
        end
      end

      S_CRC_LO: begin
        emit   = 1'b1;
        e_byte = txc_q[7:0];
        if (emit_ok) state_d = S_CRC_HI;
      end

      S_CRC_HI: begin
        emit   = 1'b1;
        e_byte = txc_q[15:8];
        e_last = 1'b1;
        if (emit_ok) state_d = S_IDLE;
      end

      S_W6: begin
        rf_we   = 1'b1;
        rf_wa   = f_start[RfAw-1:0];
        rf_wd   = f_num;
        state_d = S_ECHO_RD;
      end

      S_ECHO_RD: begin
        state_d = S_ECHO_TX;
      end

      S_ECHO_TX: begin
        emit   = 1'b1;
        e_byte = buf_rd_q;
        e_last = 10'(idx_q) + 10'd1 == 10'(len_q);
        if (emit_ok) begin
          idx_d   = idx_q + 1'b1;
          state_d = e_last ? S_IDLE : S_ECHO_RD;
        end
      end

      S_W16_RDH: begin
        buf_ra  = wr_ptr[BufAw-1:0];
        state_d = S_W16_RDL;
      end

      S_W16_RDL: begin
        hi_d    = buf_rd_q;
        buf_ra  = BufAw'(wr_ptr + 10'd1);
        state_d = S_W16_WR;
      end

      S_W16_WR: begin
        rf_we = 1'b1;
        rf_wa = ra_q;
        rf_wd = {hi_q, buf_rd_q};
        ra_d  = ra_q + 1'b1;
        idx_d = idx_q + 1'b1;
        if (16'(idx_q) + 16'd1 == f_num) begin
          idx_d   = '0;
          state_d = S_HDR;
        end else begin
          state_d = S_W16_RDH;
        end
      end

      default: state_d = S_IDLE;
    endcase

    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (emit && emit_ok) begin
      out_vld_d            = 1'b1;
      out_d.tx_valid       = e_valid;
      out_d.tx_byte        = e_byte;
      out_d.tx_last        = e_last;
      out_d.status         = e_status;
      out_d.crc_ok         = crcok_q;
      out_d.params_written = e_valid && pw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_wa] <= q_cmd_i.data;
    buf_rd_q <= buf_mem[buf_ra];
    if (hdr_we) hdr_q[hdr_wa] <= q_cmd_i.data;
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (rf_re) rf_rd_q <= rf_mem[ra_q];
    out_q    <= out_d;
    len_q    <= len_d;
    crcok_q  <= crcok_d;
    status_q <= status_d;
    plan_q   <= plan_d;
    pw_q     <= pw_d;
    idx_q    <= idx_d;
    ra_q     <= ra_d;
    txc_q    <= txc_d;
    hi_q     <= hi_d;
    b0_q     <= b0_d;
    b1_q     <= b1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      dev_q     <= 8'h01;
      man_q     <= 1'b0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      crc0_q    <= CrcInit;
      crc1_q    <= CrcInit;
      crc2_q    <= CrcInit;
      rf_vld_q  <= '0;
      rf_rv_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dev_q     <= dev_d;
      man_q     <= man_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      crc0_q    <= crc0_d;
      crc1_q    <= crc1_d;
      crc2_q    <= crc2_d;
      out_vld_q <= out_vld_d;
      if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
      if (rf_re) rf_rv_q <= rf_vld_q[ra_q];
    end
  end

endmodule
`default_nettype wire

### rtl/core/modbus_rtu_slave_register_handler.sv
`timescale 1ns / 1ps
`default_nettype none
// Modbus RTU slave over a register file of 16+TABLE_LEN 16-bit entries. Words
// enter through a two-entry queue; the executing sequencer takes each frame byte or
// device-side write from it while idle. On the frame-end byte the sequencer runs the
// checks in a decide state, then sends built headers and the CRC byte by byte, each
// echoed byte through a buffer read and a send, and each register of a read (register
// read, high byte, low byte) or multi-write (two buffer reads, register write) in
// turn; output stalls hold these steps. The register file reads as zero after
// reset through per-entry valid bits; no clearing pass runs.
module modbus_rtu_slave_register_handler import mbrtu_pkg::*; #(
  parameter int unsigned TABLE_LEN = TableLenDef,
  parameter int unsigned FRAME_MAX = FrameMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_in, q_out;

  mbrtu_front #(
    .NRegs(RegBase + TABLE_LEN)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_in)
  );

  mbrtu_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_in),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .pop_cmd_o (q_out),
    .empty_o   (q_empty)
  );

  mbrtu_back #(
    .TableLen(TABLE_LEN),
    .FrameMax(FRAME_MAX)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

### rtl/core/mbrtu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_checker import mbrtu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input in_word_t   in_word_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_word_t  out_word_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.tx_valid |-> out_word_o.tx_last)
    else $error("error word not marked last");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ST_OK)
    |-> !out_word_o.tx_valid && (out_word_o.tx_byte == 8'h00)
        && !out_word_o.params_written)
    else $error("error word carries data");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.tx_valid |-> out_word_o.status == ST_OK)
    else $error("data word with error status");

endmodule

bind modbus_rtu_slave_register_handler mbrtu_checker u_mbrtu_checker (.*);
`default_nettype wire
